// ----- design/cle_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_pkg
// types, codes and defaults shared by the cursor list engine
// ----------------------------------------------------------------------------
package cle_pkg;
  localparam int DefDepth = 1024;
  localparam int DefDataWidth = 32;
  localparam int KindW = 4;
  localparam int IdxW = 11;
  localparam int ValW = 32;
  localparam int StatW = 2;

  typedef enum logic [KindW-1:0] {
    K_CLEAR = 4'd0, K_FWD = 4'd1, K_BACK = 4'd2, K_HOME = 4'd3,
    K_RDIDX = 4'd4, K_RDCUR = 4'd5, K_INS = 4'd6, K_REM = 4'd7,
    K_TRUNC = 4'd8, K_ADD = 4'd9, K_SUB = 4'd10, K_MUL = 4'd11,
    K_DIV = 4'd12
  } kind_t;

  typedef enum logic [StatW-1:0] {
    ST_OK = 2'd0, ST_RANGE = 2'd1, ST_FULL = 2'd2, ST_DIVZ = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_RD, S_RDW, S_INSR, S_INSW, S_REMR, S_REMW,
    S_ARR, S_ARW, S_ARC, S_DIV, S_DONE, S_SHOW
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture request
    logic addr_req;  // ram read at request address
    logic addr_walk; // ram read at walk pointer
    logic addr_prev; // ram read at walk pointer - 1
    logic addr_next; // ram read at walk pointer + 1
    logic wr_ins;    // write value at walk pointer
    logic wr_rdata;  // write read data at walk pointer
    logic wr_arith;  // write arithmetic result at walk pointer
    logic walk_init_end;
    logic walk_init_idx;
    logic walk_init_zero;
    logic walk_dec;
    logic walk_inc;
    logic capture;   // latch read data for output
    logic mul_cap;   // latch add, sub or mul result
    logic div_start;
    logic commit;    // update count and cursor
    logic emit;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    kind_t kind;
    status_t check;
    logic walk_at_idx;  // walk pointer equals request index
    logic walk_last;    // walk pointer + 1 >= count (+ 2 for remove)
    logic div_done;
  } sts_t;
endpackage

// ----- design/cursor_list_engine_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cursor_list_engine_unit
// bounded signed list with cursor, insert, remove and elementwise arithmetic
// ----------------------------------------------------------------------------
// usage:
//   raise start with kind, index and value while busy is low; the item is
//   taken at that edge and busy rises until its result has been shown.
//   one result per item: done pulses for one cycle with data, length,
//   position and status. the receiver cannot stall, so it must sample then.
// sequencing:
//   clear, cursor moves, truncate and failed requests go straight to the
//   result; reads take one ram read; insert moves entries up from the end
//   down to index, remove moves entries down from index, and add, sub,
//   mul and div rewrite every element in turn, each through the single
//   ram port; the serial divider adds one quotient bit per cycle on divide.
// throughput: one item at a time, the next start is taken once busy is low.
// reset: synchronous rst empties the list and homes the cursor at once;
//   element storage is not cleared and is only read after being written.
// ----------------------------------------------------------------------------
module cursor_list_engine_unit #(
  parameter int DEPTH = cle_pkg::DefDepth,
  parameter int DATA_WIDTH = cle_pkg::DefDataWidth
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [cle_pkg::KindW-1:0]       kind,
  input  logic [cle_pkg::IdxW-1:0]        index,
  input  logic signed [cle_pkg::ValW-1:0] value,
  output logic                            done,
  output logic signed [cle_pkg::ValW-1:0] data,
  output logic [cle_pkg::IdxW-1:0]        length,
  output logic [cle_pkg::IdxW-1:0]        position,
  output logic [cle_pkg::StatW-1:0]       status
);
  import cle_pkg::*;
  ctl_t ctl;
  sts_t sts;
  logic busy_c, strobe;

  // controller sequences the ram walk, datapath owns the list state
  cle_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy_c), .sts(sts), .ctl(ctl)
  );

  cle_dp #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_dp (
    .clk(clk), .rst(rst), .kind(kind), .index(index), .value(value),
    .ctl(ctl), .sts(sts), .strobe(strobe), .data(data), .length(length),
    .position(position), .status(status)
  );

  // stay busy through the cycle the result is shown
  assign busy = busy_c | strobe;
  assign done = strobe;
endmodule

// ----- design/cle_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_ram
// single port ram with registered read
// ----------------------------------------------------------------------------
module cle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ----- design/cle_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_div
// restoring signed divider, one quotient bit per cycle, truncating
// ----------------------------------------------------------------------------
module cle_div #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic         done,
  output logic [W-1:0] q
);
  localparam int CW = $clog2(W + 1);
  logic [W-1:0] quo, dvs;
  logic [W:0] rem;
  logic [CW-1:0] cnt;
  logic neg, busy;
  logic [W:0] trial;

  assign trial = {rem[W-1:0], quo[W-1]} - {1'b0, dvs};
  assign q = neg ? (~quo + 1'b1) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CW'(W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
    if (start) begin
      quo <= a[W-1] ? (~a + 1'b1) : a;
      dvs <= b[W-1] ? (~b + 1'b1) : b;
      rem <= '0;
      neg <= a[W-1] ^ b[W-1];
    end else if (busy) begin
      if (!trial[W]) begin
        rem <= trial;
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= {rem[W-1:0], quo[W-1]};
        quo <= {quo[W-2:0], 1'b0};
      end
    end
  end
endmodule

// ----- design/cle_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_ctrl
// request sequencer for the cursor list engine
// ----------------------------------------------------------------------------
module cle_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  cle_pkg::sts_t sts,
  output cle_pkg::ctl_t ctl
);
  import cle_pkg::*;
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (start) state_next = S_DECIDE;
      S_DECIDE: begin
        if (sts.check != ST_OK) state_next = S_DONE;
        else case (sts.kind)
          K_RDIDX, K_RDCUR: state_next = S_RD;
          K_INS: state_next = sts.walk_at_idx ? S_INSW : S_INSR;
          K_REM: state_next = sts.walk_last ? S_DONE : S_REMR;
          K_ADD, K_SUB, K_MUL, K_DIV: state_next = sts.walk_last ? S_DONE : S_ARR;
          default: state_next = S_DONE;
        endcase
      end
      S_RD: state_next = S_RDW;
      S_RDW: state_next = S_DONE;
      S_INSR: state_next = S_INSW;
      S_INSW: state_next = sts.walk_at_idx ? S_DONE : S_INSR;
      S_REMR: state_next = S_REMW;
      S_REMW: state_next = sts.walk_last ? S_DONE : S_REMR;
      S_ARR: state_next = S_ARW;
      S_ARW: begin
        if (sts.kind == K_DIV) state_next = S_DIV;
        else state_next = S_ARC;
      end
      S_DIV: if (sts.div_done) state_next = S_ARC;
      S_ARC: state_next = sts.walk_last ? S_DONE : S_ARR;
      S_DONE: state_next = S_SHOW;
      S_SHOW: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    busy = (state != S_IDLE);
    case (state)
      S_IDLE: ctl.load = start;
      S_DECIDE: begin
        ctl.walk_init_end = (sts.kind == K_INS);
        ctl.walk_init_idx = (sts.kind == K_REM);
        ctl.walk_init_zero = !(sts.kind == K_INS || sts.kind == K_REM);
      end
      S_RD: ctl.addr_req = 1'b1;
      S_RDW: ctl.capture = 1'b1;
      S_INSR: ctl.addr_prev = 1'b1;
      S_INSW: begin
        ctl.addr_walk = 1'b1;
        if (sts.walk_at_idx) ctl.wr_ins = 1'b1;
        else begin
          ctl.wr_rdata = 1'b1;
          ctl.walk_dec = 1'b1;
        end
      end
      S_REMR: ctl.addr_next = 1'b1;
      S_REMW: begin
        ctl.addr_walk = 1'b1;
        ctl.wr_rdata = 1'b1;
        ctl.walk_inc = 1'b1;
      end
      S_ARR: ctl.addr_walk = 1'b1;
      S_ARW: begin
        ctl.addr_walk = 1'b1;
        ctl.mul_cap = 1'b1;
        ctl.div_start = (sts.kind == K_DIV);
      end
      S_DIV: ctl.addr_walk = 1'b1;
      S_ARC: begin
        ctl.addr_walk = 1'b1;
        ctl.wr_arith = 1'b1;
        ctl.walk_inc = 1'b1;
      end
      S_DONE: begin
        ctl.commit = 1'b1;
        ctl.emit = 1'b1;
      end
      default: ;
    endcase
  end
endmodule

// ----- design/cle_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_dp
// list storage, count, cursor, walk pointer and element arithmetic
// ----------------------------------------------------------------------------
module cle_dp #(
  parameter int DEPTH = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [cle_pkg::KindW-1:0]      kind,
  input  logic [cle_pkg::IdxW-1:0]       index,
  input  logic signed [cle_pkg::ValW-1:0] value,
  input  cle_pkg::ctl_t                  ctl,
  output cle_pkg::sts_t                  sts,
  output logic                           strobe,
  output logic signed [cle_pkg::ValW-1:0] data,
  output logic [cle_pkg::IdxW-1:0]       length,
  output logic [cle_pkg::IdxW-1:0]       position,
  output logic [cle_pkg::StatW-1:0]      status
);
  import cle_pkg::*;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > IdxW ? CW : IdxW) + 1;

  kind_t r_kind;
  logic [IdxW-1:0] r_idx;
  logic [DATA_WIDTH-1:0] r_val, rdata, result, prod, rd_cap, div_q;
  logic [CW-1:0] count, cursor;
  logic [AW-1:0] walk, addr;
  logic [PW-1:0] idx_x, cnt_x, cur_x, walk_x;
  status_t check;
  logic we, div_done;
  logic [DATA_WIDTH-1:0] wdata;

  assign idx_x = PW'(r_idx);
  assign cnt_x = PW'(count);
  assign cur_x = PW'(cursor);
  assign walk_x = PW'(walk);

  always_comb begin
    check = ST_OK;
    case (r_kind)
      K_RDIDX: if (idx_x >= cnt_x) check = ST_RANGE;
      K_RDCUR: if (cur_x >= cnt_x) check = ST_RANGE;
      K_INS: begin
        if (cnt_x >= PW'(DEPTH)) check = ST_FULL;
        else if (idx_x > cnt_x) check = ST_RANGE;
      end
      K_REM: if (idx_x >= cnt_x) check = ST_RANGE;
      K_TRUNC: if (idx_x > cnt_x) check = ST_RANGE;
      K_DIV: if (r_val == '0) check = ST_DIVZ;
      default: check = ST_OK;
    endcase
  end

  // walk_last in decide uses the walk start implied by the kind
  // remove stops once the entry just below the last one has been moved in
  always_comb begin
    sts.kind = r_kind;
    sts.check = check;
    sts.div_done = div_done;
    sts.walk_at_idx = (walk_x == idx_x);
    if (r_kind == K_REM) sts.walk_last = (walk_x + PW'(2) >= cnt_x);
    else sts.walk_last = (walk_x + 1'b1 >= cnt_x);
    if (ctl.walk_init_end || ctl.walk_init_idx || ctl.walk_init_zero) begin
      if (r_kind == K_INS) sts.walk_at_idx = (cnt_x == idx_x);
      if (r_kind == K_REM) sts.walk_last = (idx_x + 1'b1 >= cnt_x);
      else sts.walk_last = (cnt_x == '0);
    end
  end

  always_comb begin
    addr = walk;
    if (ctl.addr_req) addr = (r_kind == K_RDIDX) ? AW'(r_idx) : AW'(cursor);
    else if (ctl.addr_prev) addr = walk - 1'b1;
    else if (ctl.addr_next) addr = walk + 1'b1;
  end

  assign we = ctl.wr_ins | ctl.wr_rdata | ctl.wr_arith;
  always_comb begin
    wdata = rdata;
    if (ctl.wr_ins) wdata = r_val;
    else if (ctl.wr_arith) wdata = result;
  end

  cle_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  cle_div #(.W(DATA_WIDTH)) u_div (
    .clk(clk), .rst(rst), .start(ctl.div_start), .a(rdata), .b(r_val),
    .done(div_done), .q(div_q)
  );

  always_comb begin
    case (r_kind)
      K_ADD: result = prod;
      K_SUB: result = prod;
      K_MUL: result = prod;
      default: result = div_q;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      r_kind <= kind_t'(kind);
      r_idx <= index;
      r_val <= DATA_WIDTH'(value);
    end
    if (ctl.mul_cap) begin
      case (r_kind)
        K_ADD: prod <= rdata + r_val;
        K_SUB: prod <= rdata - r_val;
        default: prod <= DATA_WIDTH'(rdata * r_val);
      endcase
    end
    if (ctl.load) rd_cap <= '0;
    else if (ctl.capture) rd_cap <= rdata;
    if (ctl.walk_init_end) walk <= AW'(count);
    else if (ctl.walk_init_idx) walk <= AW'(r_idx);
    else if (ctl.walk_init_zero) walk <= '0;
    else if (ctl.walk_dec) walk <= walk - 1'b1;
    else if (ctl.walk_inc) walk <= walk + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      cursor <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= ctl.emit;
      if (ctl.commit && check == ST_OK) begin
        case (r_kind)
          K_CLEAR: begin
            count <= '0;
            cursor <= '0;
          end
          K_FWD: cursor <= (cursor < count) ? cursor + 1'b1 : count;
          K_BACK: if (cursor != '0) cursor <= cursor - 1'b1;
          K_HOME: cursor <= '0;
          K_INS: count <= count + 1'b1;
          K_REM: count <= count - 1'b1;
          K_TRUNC: begin
            count <= CW'(r_idx);
            if (cur_x > idx_x) cursor <= CW'(r_idx);
          end
          default: ;
        endcase
      end
    end
  end

  // result fields read the committed state in the cycle after commit
  assign data = ValW'($signed(rd_cap));
  assign length = IdxW'(count);
  assign position = IdxW'(cursor);
  always_ff @(posedge clk) begin
    if (ctl.emit) status <= check;
  end
endmodule

// ----- design/cle_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_checker
// port level checks for the cursor list engine
// ----------------------------------------------------------------------------
module cle_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [10:0] length,
  input logic [10:0] position,
  input logic [1:0]  status
);
  a_take: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("item taken but busy low");
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("result shown while idle");
  a_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result repeated");
  a_err_len: assert property (@(posedge clk) disable iff (rst)
    done && status != 2'd0 |-> length == $past(length))
    else $error("failed request changed length");
  a_err_pos: assert property (@(posedge clk) disable iff (rst)
    done && status != 2'd0 |-> position == $past(position))
    else $error("failed request moved cursor");
endmodule

bind cursor_list_engine_unit cle_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .length(length), .position(position), .status(status)
);
